// ----- rtl/ula_pkg.sv -----
package ula_pkg;

   // Store geometry.
   localparam int BUFFER_BYTES = 64;
   localparam int USABLE_BYTES = BUFFER_BYTES - 1;
   localparam int ADDR_W       = $clog2(USABLE_BYTES);
   localparam int FILL_W       = $clog2(BUFFER_BYTES);

   // Field and register widths.
   localparam int BYTE_W     = 8;
   localparam int TERM_LEN_W = 3;
   localparam int TERM_W     = 32;
   localparam int MAX_TERM   = TERM_W / BYTE_W;
   localparam int CSR_IDX_W  = 2;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_TERM_LENGTH = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TERM_BYTES  = CSR_IDX_W'(1);

   // Register reset values.
   localparam logic [TERM_LEN_W-1:0] TERM_LENGTH_RST = TERM_LEN_W'(2);
   localparam logic [TERM_W-1:0]     TERM_BYTES_RST  = TERM_W'(32'h0000_0D0A);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_LOAD
   } ula_state_type;

   // Terminator settings handed to the sequencer.
   typedef struct packed {
      logic [TERM_LEN_W-1:0] length;
      logic [TERM_W-1:0]     bytes;
   } ula_term_type;

   // One result loaded into the response stage.
   typedef struct packed {
      logic              load;
      logic [BYTE_W-1:0] line_byte;
      logic              last;
      logic              empty_line;
      logic              overflow;
   } ula_result_type;

   // Clamp the terminator length into the range 1 to 4.
   function automatic logic [TERM_LEN_W-1:0] eff_len(input logic [TERM_LEN_W-1:0] len);
      logic [TERM_LEN_W-1:0] res;
      res = len;
      if (len == '0) begin
         res = TERM_LEN_W'(1);
      end else if (len > TERM_LEN_W'(MAX_TERM)) begin
         res = TERM_LEN_W'(MAX_TERM);
      end
      return res;
   endfunction

endpackage

// ----- rtl/uart_line_assembler_core.sv -----
// Line assembler for received UART characters.
// Requests arrive on req_ (valid/ready), one character each. Each
// character is written into a line memory of 63 usable bytes and the newest
// bytes are compared against the terminator set on the csr_ port (index 0:
// terminator length, index 1: terminator bytes, last byte lowest).
// When the terminator completes a line, the text before it leaves on rsp_
// one byte per request, with rsp_last on the final byte; a bare terminator
// gives one request with rsp_empty_line. Filling the memory gives one
// request with rsp_overflow and discards the text.
// Sequence: a character is taken in the idle state; the check follows in the
// next cycle, and a flag result is loaded into the output register from the
// check state once the slot is free. Readout goes through the registered
// read port of the memory, with a read state and a load state per byte;
// a character that completes no line goes from the check state back to idle.
// Back-pressure on rsp_ holds the readout in place; nothing is lost. A new
// character may be taken while the final result still waits in the output
// register. Reset empties the line and restores the CR LF terminator; the
// memory itself needs no clearing pass.
module uart_line_assembler_core
   import ula_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [BYTE_W-1:0]    req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [BYTE_W-1:0]    rsp_line_byte,
   output logic                 rsp_last,
   output logic                 rsp_empty_line,
   output logic                 rsp_overflow,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TERM_W-1:0]    csr_wdata
);

   logic [TERM_LEN_W-1:0] term_length_ff;
   logic [TERM_W-1:0]     term_bytes_ff;
   ula_term_type          term;
   ula_result_type        result;
   logic                  slot_free;
   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_wr_addr;
   logic [BYTE_W-1:0]     ram_wr_data;
   logic                  ram_rd_en;
   logic [ADDR_W-1:0]     ram_rd_addr;
   logic [BYTE_W-1:0]     ram_rd_data;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         term_length_ff <= TERM_LENGTH_RST;
         term_bytes_ff  <= TERM_BYTES_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TERM_LENGTH: term_length_ff <= csr_wdata[TERM_LEN_W-1:0];
            CSR_TERM_BYTES:  term_bytes_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign term.length = term_length_ff;
   assign term.bytes  = term_bytes_ff;

   ula_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .term        (term),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .slot_free   (slot_free),
      .result      (result)
   );

   ula_line_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ula_rsp_stage u_rsp (
      .clock          (clock),
      .reset          (reset),
      .result         (result),
      .slot_free      (slot_free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_line_byte  (rsp_line_byte),
      .rsp_last       (rsp_last),
      .rsp_empty_line (rsp_empty_line),
      .rsp_overflow   (rsp_overflow)
   );

endmodule

// ----- rtl/ula_line_ram.sv -----
module ula_line_ram
   import ula_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [USABLE_BYTES];
   logic [BYTE_W-1:0] rd_data_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/ula_rsp_stage.sv -----
module ula_rsp_stage
   import ula_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ula_result_type    result,
   output logic              slot_free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_line_byte,
   output logic              rsp_last,
   output logic              rsp_empty_line,
   output logic              rsp_overflow
);

   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              last_ff;
   logic              empty_ff;
   logic              ovf_ff;

   // The slot may be refilled when empty or when its request leaves this cycle.
   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (result.load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (result.load) begin
         byte_ff  <= result.line_byte;
         last_ff  <= result.last;
         empty_ff <= result.empty_line;
         ovf_ff   <= result.overflow;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_line_byte  = byte_ff;
   assign rsp_last       = last_ff;
   assign rsp_empty_line = empty_ff;
   assign rsp_overflow   = ovf_ff;

endmodule

// ----- rtl/ula_seq.sv -----
module ula_seq
   import ula_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ula_term_type      term,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_rx_byte,
   output logic              ram_wr_en,
   output logic [ADDR_W-1:0] ram_wr_addr,
   output logic [BYTE_W-1:0] ram_wr_data,
   output logic              ram_rd_en,
   output logic [ADDR_W-1:0] ram_rd_addr,
   input  logic [BYTE_W-1:0] ram_rd_data,
   input  logic              slot_free,
   output ula_result_type    result
);

   ula_state_type         state_ff;
   ula_state_type         state_in;
   logic [FILL_W-1:0]     fill_ff;
   logic [FILL_W-1:0]     fill_in;
   logic [TERM_W-1:0]     recent_ff;
   logic [TERM_W-1:0]     recent_in;
   logic [ADDR_W-1:0]     rd_idx_ff;
   logic [ADDR_W-1:0]     rd_idx_in;
   logic [ADDR_W-1:0]     text_last_ff;
   logic [ADDR_W-1:0]     text_last_in;

   logic [TERM_LEN_W-1:0] len;
   logic                  is_full;
   logic                  tail_match;
   logic                  line_done;
   logic [FILL_W-1:0]     text;
   logic                  text_empty;
   logic                  read_last;
   logic                  accept;

   assign accept = req_valid && req_ready;

   // Terminator check over the newest stored bytes.
   assign len = eff_len(term.length);

   always_comb begin
      tail_match = 1'b1;
      for (int k = 0; k < MAX_TERM; k++) begin
         if (TERM_LEN_W'(k) < len) begin
            if (recent_ff[k*BYTE_W +: BYTE_W] != term.bytes[k*BYTE_W +: BYTE_W]) begin
               tail_match = 1'b0;
            end
         end
      end
   end

   assign is_full    = (fill_ff == FILL_W'(USABLE_BYTES));
   assign line_done  = (fill_ff >= FILL_W'(len)) && tail_match;
   assign text       = fill_ff - FILL_W'(len);
   assign text_empty = (text == '0);
   assign read_last  = (rd_idx_ff == text_last_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (is_full || (line_done && text_empty)) begin
               if (slot_free) begin
                  state_in = ST_IDLE;
               end
            end else if (line_done) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (slot_free) begin
               state_in = read_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath updates.
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      ram_wr_en    = accept;
      ram_wr_addr  = fill_ff[ADDR_W-1:0];
      ram_wr_data  = req_rx_byte;
      ram_rd_en    = (state_ff == ST_READ);
      ram_rd_addr  = rd_idx_ff;
      result       = '0;
      fill_in      = fill_ff;
      recent_in    = recent_ff;
      rd_idx_in    = rd_idx_ff;
      text_last_in = text_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               fill_in   = fill_ff + FILL_W'(1);
               recent_in = {recent_ff[TERM_W-BYTE_W-1:0], req_rx_byte};
            end
         end
         ST_CHECK: begin
            if (is_full) begin
               if (slot_free) begin
                  result.load     = 1'b1;
                  result.last     = 1'b1;
                  result.overflow = 1'b1;
                  fill_in         = '0;
                  recent_in       = '0;
               end
            end else if (line_done && text_empty) begin
               if (slot_free) begin
                  result.load       = 1'b1;
                  result.last       = 1'b1;
                  result.empty_line = 1'b1;
                  fill_in           = '0;
                  recent_in         = '0;
               end
            end else if (line_done) begin
               // The line length is kept so the store can be cleared now.
               text_last_in = text[ADDR_W-1:0] - ADDR_W'(1);
               rd_idx_in    = '0;
               fill_in      = '0;
               recent_in    = '0;
            end
         end
         ST_LOAD: begin
            if (slot_free) begin
               result.load      = 1'b1;
               result.line_byte = ram_rd_data;
               result.last      = read_last;
               rd_idx_in        = rd_idx_ff + ADDR_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         recent_ff <= '0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         recent_ff <= recent_in;
      end
   end

   // Readout pointers need no reset.
   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      text_last_ff <= text_last_in;
   end

endmodule

// ----- dv/tb_uart_line_assembler_core.sv -----
module tb_uart_line_assembler_core;
   timeunit 1ns;
   timeprecision 1ps;

   import ula_pkg::*;

   // Run limits and pacing.
   localparam int STALL_LIMIT   = 2000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 16;
   localparam int MAX_SHOWN     = 10;

   // An index that selects no register; a write to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = CSR_IDX_W'(3);

   localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

   typedef struct packed {
      logic [BYTE_W-1:0] line_byte;
      logic              last;
      logic              empty_line;
      logic              overflow;
   } line_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [BYTE_W-1:0]    req_rx_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [BYTE_W-1:0]    rsp_line_byte;
   logic                 rsp_last;
   logic                 rsp_empty_line;
   logic                 rsp_overflow;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TERM_W-1:0]    csr_wdata = '0;

   // Characters waiting to be offered, and line results still owed by the block.
   logic [BYTE_W-1:0] pending_chars[$];
   line_result_type   owed_results[$];

   // Shadow copy of the line store, its fill level and the terminator settings.
   logic [BYTE_W-1:0]     shadow_store[USABLE_BYTES];
   int unsigned           shadow_fill = 0;
   logic [TERM_W-1:0]     shadow_recent = '0;
   logic [TERM_LEN_W-1:0] shadow_term_len = TERM_LENGTH_RST;
   logic [TERM_W-1:0]     shadow_term_bytes = TERM_BYTES_RST;

   int gap_pct = 0;
   int stall_pct = 0;
   int hold_ticket = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int idle_cycles = 0;

   int chars_queued = 0;
   int chars_taken = 0;
   int results_seen = 0;
   int line_bytes_seen = 0;
   int empty_seen = 0;
   int overflow_seen = 0;
   int error_count = 0;

   line_result_type   got_result;
   line_result_type   want_result;
   logic [TERM_W-1:0] phase_term;

   uart_line_assembler_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_line_byte  (rsp_line_byte),
      .rsp_last       (rsp_last),
      .rsp_empty_line (rsp_empty_line),
      .rsp_overflow   (rsp_overflow),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Appends one character to the shadow line and queues whatever it completes.
   function automatic void assemble_char(input logic [BYTE_W-1:0] ch);
      int unsigned     n;
      int unsigned     text;
      logic [TERM_W-1:0] mask;
      line_result_type r;
      shadow_store[shadow_fill] = ch;
      shadow_fill++;
      shadow_recent = {shadow_recent[TERM_W-BYTE_W-1:0], ch};
      r = '0;
      // A full store is thrown away without looking for a terminator.
      if (shadow_fill >= USABLE_BYTES) begin
         r.last = 1'b1;
         r.overflow = 1'b1;
         owed_results.push_back(r);
         shadow_fill = 0;
         shadow_recent = '0;
         return;
      end
      n = shadow_term_len;
      if (n == 0) begin
         n = 1;
      end else if (n > MAX_TERM) begin
         n = MAX_TERM;
      end
      if (shadow_fill < n) begin
         return;
      end
      mask = '1;
      if (n < MAX_TERM) begin
         mask = (TERM_W'(1) << (BYTE_W * n)) - TERM_W'(1);
      end
      if ((shadow_recent & mask) != (shadow_term_bytes & mask)) begin
         return;
      end
      text = shadow_fill - n;
      if (text == 0) begin
         r.last = 1'b1;
         r.empty_line = 1'b1;
         owed_results.push_back(r);
      end else begin
         for (int unsigned i = 0; i < text; i++) begin
            r.line_byte = shadow_store[i];
            r.last = (i + 1 == text);
            owed_results.push_back(r);
         end
      end
      shadow_fill = 0;
      shadow_recent = '0;
   endfunction

   // Text character that can never complete the terminator by itself.
   function automatic logic [BYTE_W-1:0] text_char(input logic [BYTE_W-1:0] avoid);
      logic [BYTE_W-1:0] ch;
      do begin
         ch = BYTE_W'($urandom_range(1, 255));
      end while (ch == avoid);
      return ch;
   endfunction

   task automatic flag_error(input string msg);
      if (error_count < MAX_SHOWN) begin
         $display("%s", msg);
      end
      error_count++;
   endtask

   task automatic push_char(input logic [BYTE_W-1:0] ch);
      pending_chars.push_back(ch);
      chars_queued++;
   endtask

   // The first count bytes of the terminator, earliest byte first.
   task automatic push_term_head(input int unsigned count, input int unsigned n,
                                 input logic [TERM_W-1:0] term);
      for (int unsigned i = 0; i < count; i++) begin
         push_char(term[BYTE_W*(n-1-i) +: BYTE_W]);
      end
   endtask

   task automatic push_line(input int unsigned text_len, input int unsigned n,
                            input logic [TERM_W-1:0] term);
      for (int unsigned i = 0; i < text_len; i++) begin
         push_char(text_char(term[BYTE_W-1:0]));
      end
      push_term_head(n, n, term);
   endtask

   // Mostly complete lines, with loose characters and cut-off terminators mixed in.
   task automatic random_traffic(input int unsigned n, input logic [TERM_W-1:0] term,
                                 input int count);
      int start;
      int pick;
      int unsigned k;
      start = chars_queued;
      while (chars_queued - start < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            if ($urandom_range(0, 9) == 0) begin
               k = $urandom_range(30, USABLE_BYTES - 1 - n);
            end else begin
               k = $urandom_range(0, 10);
            end
            push_line(k, n, term);
         end else if (pick < 85 || n == 1) begin
            k = $urandom_range(1, 6);
            repeat (k) push_char(BYTE_W'($urandom_range(1, 255)));
         end else begin
            push_term_head($urandom_range(1, n - 1), n, term);
            push_char(text_char(term[BYTE_W-1:0]));
         end
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [TERM_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_TERM_LENGTH) begin
         shadow_term_len = data[TERM_LEN_W-1:0];
      end else if (idx == CSR_TERM_BYTES) begin
         shadow_term_bytes = data;
      end
      @(negedge clock);
   endtask

   task automatic set_terminator(input logic [TERM_LEN_W-1:0] len,
                                 input logic [TERM_W-1:0] term);
      write_reg(CSR_TERM_LENGTH, TERM_W'(len));
      write_reg(CSR_TERM_BYTES, term);
   endtask

   // Waits for the last character and result, then lets a pending check finish.
   task automatic wait_until_drained();
      while (pending_chars.size() != 0 || req_valid || owed_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Request driver: offers queued characters and shadows each accepted one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            assemble_char(req_rx_byte);
            chars_taken++;
         end
         if (!req_valid || req_ready) begin
            if (pending_chars.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
               req_valid <= 1'b1;
               req_rx_byte <= pending_chars.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each accepted request against the oldest owed result.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            got_result = {rsp_line_byte, rsp_last, rsp_empty_line, rsp_overflow};
            if (owed_results.size() == 0) begin
               flag_error($sformatf({"result %0d arrived with none owed: byte %02h ",
                  "last %0b empty %0b overflow %0b"},
                  results_seen, rsp_line_byte, rsp_last, rsp_empty_line, rsp_overflow));
            end else begin
               want_result = owed_results.pop_front();
               if (got_result !== want_result) begin
                  flag_error($sformatf({"result %0d: expected byte %02h last %0b empty %0b ",
                     "overflow %0b, got byte %02h last %0b empty %0b overflow %0b"},
                     results_seen, want_result.line_byte, want_result.last,
                     want_result.empty_line, want_result.overflow, rsp_line_byte,
                     rsp_last, rsp_empty_line, rsp_overflow));
               end else if (rsp_overflow) begin
                  overflow_seen++;
               end else if (rsp_empty_line) begin
                  empty_seen++;
               end else begin
                  line_bytes_seen++;
               end
            end
         end
         // A long hold-off, when asked for, overrides the random stalls.
         if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // Ends the run when no channel has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Timed out with %0d characters queued and %0d results owed.",
                  pending_chars.size(), owed_results.size());
         $display("tb_uart_line_assembler_core: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset terminator: bare CR LF, a plain line, extreme and zero characters,
      // and a lone LF too short to match.
      push_char(CHAR_CR);
      push_char(CHAR_LF);
      push_char(8'h41);
      push_char(CHAR_CR);
      push_char(CHAR_LF);
      push_char(8'h01);
      push_char(8'hFF);
      push_char(8'h00);
      push_char(CHAR_CR);
      push_char(CHAR_LF);
      push_char(CHAR_LF);
      push_char(CHAR_CR);
      push_char(CHAR_LF);
      wait_until_drained();

      // Length zero acts as one; a zero terminator matches only a received zero.
      set_terminator(TERM_LEN_W'(0), '0);
      push_char(8'h78);
      push_char(8'h00);
      push_char(8'h00);
      wait_until_drained();

      // Length seven acts as four; the bytes of the last line must not count.
      set_terminator(TERM_LEN_W'(7), '1);
      write_reg(CSR_SPARE_INDEX, TERM_W'($urandom()));
      push_char(8'h71);
      repeat (4) push_char(8'hFF);
      repeat (4) push_char(8'hFF);
      wait_until_drained();

      // CR LF again, no idling.
      gap_pct = 0;
      stall_pct = 0;
      set_terminator(TERM_LENGTH_RST, TERM_BYTES_RST);
      random_traffic(2, TERM_BYTES_RST, 50);
      wait_until_drained();

      // Single-byte terminator with the longest line the store allows; sender idles.
      phase_term = TERM_W'($urandom());
      gap_pct = 60;
      set_terminator(TERM_LEN_W'(1), phase_term);
      push_line(USABLE_BYTES - 2, 1, phase_term);
      random_traffic(1, phase_term, 50);
      wait_until_drained();

      // Four-byte terminator, a store overflow, and a long receiver hold-off
      // while characters keep coming.
      phase_term = TERM_W'($urandom());
      gap_pct = 0;
      stall_pct = 60;
      set_terminator(TERM_LEN_W'(4), phase_term);
      hold_ticket++;
      repeat (USABLE_BYTES) push_char(text_char(phase_term[BYTE_W-1:0]));
      random_traffic(4, phase_term, 50);
      wait_until_drained();

      // Three-byte terminator, both sides idling, with a full pause halfway.
      phase_term = TERM_W'($urandom());
      gap_pct = 18;
      stall_pct = 18;
      set_terminator(TERM_LEN_W'(3), phase_term);
      random_traffic(3, phase_term, 25);
      wait_until_drained();
      random_traffic(3, phase_term, 25);
      wait_until_drained();

      // Length five acts as four, no idling.
      phase_term = TERM_W'($urandom());
      gap_pct = 0;
      stall_pct = 0;
      set_terminator(TERM_LEN_W'(5), phase_term);
      random_traffic(4, phase_term, 50);
      wait_until_drained();

      $display("Sent %0d characters under eight terminator settings and four idling mixes.",
               chars_taken);
      $display("Checked %0d results: %0d line bytes, %0d empty lines, %0d overflows.",
               results_seen, line_bytes_seen, empty_seen, overflow_seen);
      if (error_count == 0) begin
         $display("tb_uart_line_assembler_core: done, clean");
      end else begin
         $display("tb_uart_line_assembler_core: done, errors");
      end
      $finish;
   end

endmodule

// ----- uart_line_assembler_core.f -----
rtl/ula_pkg.sv
rtl/ula_line_ram.sv
rtl/ula_rsp_stage.sv
rtl/ula_seq.sv
rtl/uart_line_assembler_core.sv
dv/tb_uart_line_assembler_core.sv
